@@ src/flvavc_pkg.sv @@
// shared constants, state encodings and the result item type of the flv to annex b demux
package flvavc_pkg;

  // parameter set store sizes
  localparam int SPS_CAPACITY = 32;
  localparam int PPS_CAPACITY = 16;
  localparam int SPS_AW = $clog2(SPS_CAPACITY);
  localparam int PPS_AW = $clog2(PPS_CAPACITY);
  localparam int SPS_CW = $clog2(SPS_CAPACITY + 1);
  localparam int PPS_CW = $clog2(PPS_CAPACITY + 1);
  // burst index covers both stores and the four bytes of a start code
  localparam int SEQ_W = (SPS_AW > PPS_AW) ? SPS_AW : PPS_AW;

  // stream layout
  localparam logic [3:0]  FILE_HEADER_LAST = 4'd12;  // 13 byte file header
  localparam logic [3:0]  TAG_HEADER_LAST  = 4'd10;  // 11 byte tag header
  localparam logic [3:0]  SIZE_LAST_BYTE   = 4'd3;   // body size sits in tag header bytes 1..3
  localparam logic [1:0]  TRAILER_LAST     = 2'd3;   // 4 byte previous-tag-size trailer
  localparam logic [7:0]  VIDEO_TAG        = 8'd9;
  localparam logic [23:0] PAYLOAD_OFFSET   = 24'd9;
  localparam logic [23:0] LEN_OFFSET       = 24'd11;
  localparam logic [7:0]  AVC_SEQ_HEADER   = 8'd0;
  localparam logic [7:0]  AVC_NALU         = 8'd1;
  localparam logic [3:0]  KEY_FRAME_TYPE   = 4'h1;
  localparam logic [7:0]  START_CODE_TAIL  = 8'h01;

  typedef enum logic [3:0] {
    PH_FILE    = 4'b0001,
    PH_TAGHDR  = 4'b0010,
    PH_BODY    = 4'b0100,
    PH_TRAILER = 4'b1000
  } phase_t;

  typedef enum logic [7:0] {
    CS_PRE      = 8'b0000_0001,
    CS_SPS_LO   = 8'b0000_0010,
    CS_SPS_DATA = 8'b0000_0100,
    CS_PPS_NUM  = 8'b0000_1000,
    CS_PPS_HI   = 8'b0001_0000,
    CS_PPS_LO   = 8'b0010_0000,
    CS_PPS_DATA = 8'b0100_0000,
    CS_DONE     = 8'b1000_0000
  } cfg_stage_t;

  typedef enum logic [5:0] {
    BU_IDLE = 6'b00_0001,
    BU_SC1  = 6'b00_0010,
    BU_SPS  = 6'b00_0100,
    BU_SC2  = 6'b00_1000,
    BU_PPS  = 6'b01_0000,
    BU_SC3  = 6'b10_0000
  } burst_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_first;
    logic       frame_last;
    logic       run_last;
  } out_item_t;

endpackage

@@ src/flvavc_if.sv @@
// valid/ready stream interfaces for the raw flv input and the annex b output
interface flvavc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface flvavc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_first;
  logic       frame_last;
  logic       run_last;

  modport source (output valid, output out_byte, output frame_first, output frame_last,
                  output run_last, input ready);
  modport sink (input valid, input out_byte, input frame_first, input frame_last,
                input run_last, output ready);
endinterface

@@ src/flvavc_ram.sv @@
// simple dual port ram, one write port and one registered read port
module flvavc_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/flvavc_out_reg.sv @@
// output holding register that decouples the sequencer from downstream stalls
module flvavc_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  flvavc_pkg::out_item_t item,
  output logic                  free,
  flvavc_out_if.source          out_stream
);

  logic                  full;
  flvavc_pkg::out_item_t held;

  // slot can take a new transaction when empty or draining this cycle
  assign free = !full || out_stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (out_stream.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= item;
    end
  end

  assign out_stream.valid       = full;
  assign out_stream.out_byte    = held.out_byte;
  assign out_stream.frame_first = held.frame_first;
  assign out_stream.frame_last  = held.frame_last;
  assign out_stream.run_last    = held.run_last;

endmodule

@@ src/flv_avc_to_annexb_demux_core.sv @@
// top level of the flv to annex b video demux: parser, parameter set rams and burst sequencer
//
// Takes an flv byte stream one transaction per byte and gives the annex b byte stream of its
// avc video. The 13 byte file header is skipped, then every tag is walked: 11 byte header
// (type and 24-bit body size), body, 4 byte trailer. Only video tags are looked into. From a
// sequence header (avc packet type 0) the first sps and pps are kept in two small rams,
// clipped to their capacity. A nalu packet (avc packet type 1) opens an access unit: the
// byte at body offset 1 starts a burst of start code 00 00 00 01, and for keyframes also the
// stored sps, a start code, the stored pps and a start code; after that every body byte
// from offset 9 goes straight out as it arrives. frame_first marks the first byte of the
// access unit, frame_last its final byte, run_last the last output caused by one input byte.
// Rate: one input byte per cycle while the output side keeps up. The byte that opens an
// access unit holds the input for the length of its burst, one output byte a cycle while
// the output slot is free, set by the burst sequencer walking the read port of the
// parameter set rams. The rams need no clearing pass:
// an entry is only ever read below the fill count of the last stored set.
module flv_avc_to_annexb_demux_core (
  input  logic         clk,
  input  logic         rst,
  flvavc_in_if.sink    in_stream,
  flvavc_out_if.source out_stream
);

  // parser state
  flvavc_pkg::phase_t                 phase, phase_next;
  logic [3:0]                         header_count, header_count_next;
  logic                               is_video, is_video_next;
  logic [23:0]                        body_length, body_length_next;
  logic [23:0]                        body_position, body_position_next;
  logic [1:0]                         trailer_count, trailer_count_next;
  logic                               keyframe, keyframe_next;
  logic                               avc_cfg, avc_cfg_next;   // avc packet type 0
  logic                               avc_pic, avc_pic_next;   // avc packet type 1
  flvavc_pkg::cfg_stage_t             cfg_stage, cfg_stage_next;
  logic [7:0]                         length_high, length_high_next;
  logic [15:0]                        section_left, section_left_next;
  logic [flvavc_pkg::SPS_CW-1:0]      sps_count, sps_count_next;
  logic [flvavc_pkg::PPS_CW-1:0]      pps_count, pps_count_next;

  // burst sequencer state
  flvavc_pkg::burst_t                 burst, burst_next;
  logic [flvavc_pkg::SEQ_W-1:0]       seq_idx, seq_idx_next;
  logic                               burst_key, burst_key_next;
  logic                               burst_end, burst_end_next;

  // ram ports
  logic                               sps_we, pps_we;
  logic [flvavc_pkg::SPS_AW-1:0]      sps_waddr;
  logic [flvavc_pkg::PPS_AW-1:0]      pps_waddr;
  logic [7:0]                         sps_rdata, pps_rdata;

  // output side
  logic                               out_free;
  logic                               emit_valid;
  flvavc_pkg::out_item_t              emit_item;

  logic                               accept;
  logic [23:0]                        pos_inc;
  logic [15:0]                        sec_len;
  logic [flvavc_pkg::SEQ_W:0]         idx_inc;
  logic                               sc_end;
  logic [7:0]                         sc_byte;

  // input waits while a burst runs or the output slot is full and not draining
  assign in_stream.ready = (burst == flvavc_pkg::BU_IDLE) && out_free;
  assign accept          = in_stream.valid && in_stream.ready;

  assign pos_inc = body_position + 24'd1;
  assign sec_len = {length_high, in_stream.in_byte};
  assign idx_inc = {1'b0, seq_idx} + {{flvavc_pkg::SEQ_W{1'b0}}, 1'b1};
  assign sc_end  = (seq_idx == flvavc_pkg::SEQ_W'(3));
  assign sc_byte = sc_end ? flvavc_pkg::START_CODE_TAIL : 8'h00;

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    is_video_next      = is_video;
    body_length_next   = body_length;
    body_position_next = body_position;
    trailer_count_next = trailer_count;
    keyframe_next      = keyframe;
    avc_cfg_next       = avc_cfg;
    avc_pic_next       = avc_pic;
    cfg_stage_next     = cfg_stage;
    length_high_next   = length_high;
    section_left_next  = section_left;
    sps_count_next     = sps_count;
    pps_count_next     = pps_count;
    burst_next         = burst;
    seq_idx_next       = seq_idx;
    burst_key_next     = burst_key;
    burst_end_next     = burst_end;
    sps_we             = 1'b0;
    pps_we             = 1'b0;
    sps_waddr          = sps_count[flvavc_pkg::SPS_AW-1:0];
    pps_waddr          = pps_count[flvavc_pkg::PPS_AW-1:0];
    emit_valid         = 1'b0;
    emit_item          = '0;

    if (accept) begin
      unique case (phase)
        flvavc_pkg::PH_FILE: begin
          // file header bytes are skipped unchecked
          if (header_count == flvavc_pkg::FILE_HEADER_LAST) begin
            header_count_next = 4'd0;
            phase_next        = flvavc_pkg::PH_TAGHDR;
          end else begin
            header_count_next = header_count + 4'd1;
          end
        end
        flvavc_pkg::PH_TAGHDR: begin
          if (header_count == 4'd0) begin
            is_video_next = (in_stream.in_byte == flvavc_pkg::VIDEO_TAG);
          end else if (header_count <= flvavc_pkg::SIZE_LAST_BYTE) begin
            body_length_next = {body_length[15:0], in_stream.in_byte};
          end
          if (header_count == flvavc_pkg::TAG_HEADER_LAST) begin
            header_count_next  = 4'd0;
            body_position_next = 24'd0;
            trailer_count_next = 2'd0;
            phase_next = (body_length != 24'd0) ? flvavc_pkg::PH_BODY : flvavc_pkg::PH_TRAILER;
          end else begin
            header_count_next = header_count + 4'd1;
          end
        end
        flvavc_pkg::PH_BODY: begin
          if (is_video) begin
            if (body_position == 24'd0) begin
              keyframe_next = (in_stream.in_byte[7:4] == flvavc_pkg::KEY_FRAME_TYPE);
            end else if (body_position == 24'd1) begin
              avc_cfg_next   = (in_stream.in_byte == flvavc_pkg::AVC_SEQ_HEADER);
              avc_pic_next   = (in_stream.in_byte == flvavc_pkg::AVC_NALU);
              cfg_stage_next = flvavc_pkg::CS_PRE;
              if (in_stream.in_byte == flvavc_pkg::AVC_NALU) begin
                // open an access unit; a keyframe carries the parameter sets first
                burst_key_next = keyframe;
                burst_end_next = (body_length <= flvavc_pkg::PAYLOAD_OFFSET);
                seq_idx_next   = '0;
                burst_next     = keyframe ? flvavc_pkg::BU_SC1 : flvavc_pkg::BU_SC3;
              end
            end else if (avc_cfg) begin
              // decoder configuration record: pick out the first sps and pps
              unique case (cfg_stage)
                flvavc_pkg::CS_PRE: begin
                  if (body_position == flvavc_pkg::LEN_OFFSET) begin
                    length_high_next = in_stream.in_byte;
                    cfg_stage_next   = flvavc_pkg::CS_SPS_LO;
                  end
                end
                flvavc_pkg::CS_SPS_LO: begin
                  section_left_next = sec_len;
                  sps_count_next    = '0;
                  cfg_stage_next    = (sec_len != 16'd0) ? flvavc_pkg::CS_SPS_DATA
                                                         : flvavc_pkg::CS_PPS_NUM;
                end
                flvavc_pkg::CS_SPS_DATA: begin
                  if (sps_count < flvavc_pkg::SPS_CW'(flvavc_pkg::SPS_CAPACITY)) begin
                    sps_we         = 1'b1;
                    sps_count_next = sps_count + flvavc_pkg::SPS_CW'(1);
                  end
                  section_left_next = section_left - 16'd1;
                  if (section_left == 16'd1) begin
                    cfg_stage_next = flvavc_pkg::CS_PPS_NUM;
                  end
                end
                flvavc_pkg::CS_PPS_NUM: begin
                  cfg_stage_next = flvavc_pkg::CS_PPS_HI;
                end
                flvavc_pkg::CS_PPS_HI: begin
                  length_high_next = in_stream.in_byte;
                  cfg_stage_next   = flvavc_pkg::CS_PPS_LO;
                end
                flvavc_pkg::CS_PPS_LO: begin
                  section_left_next = sec_len;
                  pps_count_next    = '0;
                  cfg_stage_next    = (sec_len != 16'd0) ? flvavc_pkg::CS_PPS_DATA
                                                         : flvavc_pkg::CS_DONE;
                end
                flvavc_pkg::CS_PPS_DATA: begin
                  if (pps_count < flvavc_pkg::PPS_CW'(flvavc_pkg::PPS_CAPACITY)) begin
                    pps_we         = 1'b1;
                    pps_count_next = pps_count + flvavc_pkg::PPS_CW'(1);
                  end
                  section_left_next = section_left - 16'd1;
                  if (section_left == 16'd1) begin
                    cfg_stage_next = flvavc_pkg::CS_DONE;
                  end
                end
                flvavc_pkg::CS_DONE: begin
                  cfg_stage_next = cfg_stage;
                end
                default: begin
                  cfg_stage_next = cfg_stage;
                end
              endcase
            end else if (avc_pic && (body_position >= flvavc_pkg::PAYLOAD_OFFSET)) begin
              // picture payload passes straight through
              emit_valid            = 1'b1;
              emit_item.out_byte    = in_stream.in_byte;
              emit_item.frame_first = 1'b0;
              emit_item.frame_last  = ({1'b0, body_position} + 25'd1) == {1'b0, body_length};
              emit_item.run_last    = 1'b1;
            end
          end
          body_position_next = pos_inc;
          if (pos_inc >= body_length) begin
            phase_next         = flvavc_pkg::PH_TRAILER;
            trailer_count_next = 2'd0;
          end
        end
        flvavc_pkg::PH_TRAILER: begin
          trailer_count_next = trailer_count + 2'd1;
          if (trailer_count == flvavc_pkg::TRAILER_LAST) begin
            phase_next        = flvavc_pkg::PH_TAGHDR;
            header_count_next = 4'd0;
            body_length_next  = 24'd0;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end else if ((burst != flvavc_pkg::BU_IDLE) && out_free) begin
      // one prefix byte per free output slot; ram data is prefetched from seq_idx_next
      emit_valid = 1'b1;
      unique case (burst)
        flvavc_pkg::BU_SC1: begin
          emit_item.out_byte    = sc_byte;
          emit_item.frame_first = (seq_idx == '0);
          if (sc_end) begin
            seq_idx_next = '0;
            burst_next   = (sps_count != '0) ? flvavc_pkg::BU_SPS : flvavc_pkg::BU_SC2;
          end else begin
            seq_idx_next = idx_inc[flvavc_pkg::SEQ_W-1:0];
          end
        end
        flvavc_pkg::BU_SPS: begin
          emit_item.out_byte = sps_rdata;
          if (idx_inc == (flvavc_pkg::SEQ_W + 1)'(sps_count)) begin
            seq_idx_next = '0;
            burst_next   = flvavc_pkg::BU_SC2;
          end else begin
            seq_idx_next = idx_inc[flvavc_pkg::SEQ_W-1:0];
          end
        end
        flvavc_pkg::BU_SC2: begin
          emit_item.out_byte = sc_byte;
          if (sc_end) begin
            seq_idx_next = '0;
            burst_next   = (pps_count != '0) ? flvavc_pkg::BU_PPS : flvavc_pkg::BU_SC3;
          end else begin
            seq_idx_next = idx_inc[flvavc_pkg::SEQ_W-1:0];
          end
        end
        flvavc_pkg::BU_PPS: begin
          emit_item.out_byte = pps_rdata;
          if (idx_inc == (flvavc_pkg::SEQ_W + 1)'(pps_count)) begin
            seq_idx_next = '0;
            burst_next   = flvavc_pkg::BU_SC3;
          end else begin
            seq_idx_next = idx_inc[flvavc_pkg::SEQ_W-1:0];
          end
        end
        flvavc_pkg::BU_SC3: begin
          // last start code; opens the unit itself for an inter frame, where no parameter sets come before
          emit_item.out_byte    = sc_byte;
          emit_item.frame_first = !burst_key && (seq_idx == '0);
          emit_item.frame_last  = sc_end && burst_end;
          emit_item.run_last    = sc_end;
          if (sc_end) begin
            seq_idx_next = '0;
            burst_next   = flvavc_pkg::BU_IDLE;
          end else begin
            seq_idx_next = idx_inc[flvavc_pkg::SEQ_W-1:0];
          end
        end
        default: begin
          emit_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= flvavc_pkg::PH_FILE;
      header_count  <= 4'd0;
      is_video      <= 1'b0;
      body_length   <= 24'd0;
      body_position <= 24'd0;
      trailer_count <= 2'd0;
      keyframe      <= 1'b0;
      avc_cfg       <= 1'b1;
      avc_pic       <= 1'b0;
      cfg_stage     <= flvavc_pkg::CS_PRE;
      sps_count     <= '0;
      pps_count     <= '0;
      burst         <= flvavc_pkg::BU_IDLE;
      seq_idx       <= '0;
      burst_key     <= 1'b0;
      burst_end     <= 1'b0;
    end else begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      is_video      <= is_video_next;
      body_length   <= body_length_next;
      body_position <= body_position_next;
      trailer_count <= trailer_count_next;
      keyframe      <= keyframe_next;
      avc_cfg       <= avc_cfg_next;
      avc_pic       <= avc_pic_next;
      cfg_stage     <= cfg_stage_next;
      sps_count     <= sps_count_next;
      pps_count     <= pps_count_next;
      burst         <= burst_next;
      seq_idx       <= seq_idx_next;
      burst_key     <= burst_key_next;
      burst_end     <= burst_end_next;
    end
  end

  // length bytes need no reset: always loaded before they are looked at
  always_ff @(posedge clk) begin
    length_high  <= length_high_next;
    section_left <= section_left_next;
  end

  // parameter set stores; written only while the input is taken, read data used only in
  // bursts, so a write and a used read of the same entry never meet
  flvavc_ram #(
    .DEPTH (flvavc_pkg::SPS_CAPACITY),
    .WIDTH (8)
  ) u_sps_ram (
    .clk   (clk),
    .we    (sps_we),
    .waddr (sps_waddr),
    .wdata (in_stream.in_byte),
    .raddr (seq_idx_next[flvavc_pkg::SPS_AW-1:0]),
    .rdata (sps_rdata)
  );

  flvavc_ram #(
    .DEPTH (flvavc_pkg::PPS_CAPACITY),
    .WIDTH (8)
  ) u_pps_ram (
    .clk   (clk),
    .we    (pps_we),
    .waddr (pps_waddr),
    .wdata (in_stream.in_byte),
    .raddr (seq_idx_next[flvavc_pkg::PPS_AW-1:0]),
    .rdata (pps_rdata)
  );

  // output slot: takes a new transaction while the previous one drains
  flvavc_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (emit_valid),
    .item       (emit_item),
    .free       (out_free),
    .out_stream (out_stream)
  );

endmodule
